@@ rtl/ipv6p_pkg.sv @@
// shared types, constants and the hex digit decoder of the ipv6 text parser
// no dependencies

package ipv6p_pkg;

	localparam int unsigned GroupCount = 8;
	localparam logic [5:0]  MaxInner   = 6'd39;

	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChOpen  = 8'h5B;
	localparam logic [7:0] ChClose = 8'h5D;

	typedef logic [GroupCount-1:0][15:0] group_vec_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_digit_t;

	typedef struct packed {
		group_vec_t hi;
		group_vec_t lo;
		logic [3:0] gb;
		logic [3:0] ga;
		logic [15:0] cur;
		logic       has_digits;
		logic       gap;
		logic       err;
	} scan_snap_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.is_hex = 1'b0;
		d.value  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.is_hex = 1'b1;
			d.value  = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			d.is_hex = 1'b1;
			d.value  = c[3:0] + 4'd9;
		end
		return d;
	endfunction

endpackage

@@ rtl/ipv6p_char_if.sv @@
// character channel: valid/ready handshake, one text character per beat
// no dependencies

interface ipv6p_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

@@ rtl/ipv6p_addr_if.sv @@
// address result channel: valid/ready handshake, one parsed address per beat
// no dependencies

interface ipv6p_addr_if;
	logic        valid;
	logic        ready;
	logic        addr_valid;
	logic [63:0] addr_high;
	logic [63:0] addr_low;

	modport source (output valid, output addr_valid, output addr_high, output addr_low,
		input ready);
	modport sink   (input valid, input addr_valid, input addr_high, input addr_low,
		output ready);
endinterface

@@ rtl/ipv6p_scan.sv @@
// input register and per-character parse state; hands a state snapshot on the last beat
// depends on ipv6p_pkg and ipv6p_char_if

module ipv6p_scan import ipv6p_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ipv6p_char_if.sink chars,
	output scan_snap_t snap,
	output logic       snap_valid,
	input  logic       snap_ready
);

	logic       v_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       adv_s1;

	group_vec_t  hi_q, lo_q, n_hi, n_lo;
	logic [3:0]  gb_q, ga_q, n_gb, n_ga;
	logic [15:0] cur_q, n_cur;
	logic [2:0]  dc_q, n_dc;
	logic        gap_q, n_gap;
	logic        pc_q, n_pc;
	logic [5:0]  cc_q, n_cc;
	logic        bo_q, n_bo;
	logic        st_q;
	logic        err_q, n_err;

	scan_snap_t snap_s2;
	logic       snap_valid_s2;

	hex_digit_t hx;
	logic [3:0] total;

	assign adv_s1      = v_s1 && (!last_s1 || !snap_valid_s2 || snap_ready);
	assign chars.ready = !v_s1 || adv_s1;
	assign hx          = hex_decode(char_s1);
	assign total       = gb_q + ga_q;

	always_comb begin
		n_hi  = hi_q;
		n_lo  = lo_q;
		n_gb  = gb_q;
		n_ga  = ga_q;
		n_cur = cur_q;
		n_dc  = dc_q;
		n_gap = gap_q;
		n_pc  = pc_q;
		n_cc  = cc_q;
		n_bo  = bo_q;
		n_err = err_q;
		if (st_q && char_s1 == ChOpen) begin
			n_bo = 1'b1;
			if (last_s1) n_err = 1'b1;
		end else if (last_s1 && bo_q) begin
			if (char_s1 != ChClose) n_err = 1'b1;
		end else if (!err_q) begin
			if (cc_q >= MaxInner) begin
				n_err = 1'b1;
			end else begin
				n_cc = cc_q + 6'd1;
				if (hx.is_hex) begin
					// a digit after a lone leading colon
					if (pc_q && !gap_q && gb_q == 4'd0) begin
						n_err = 1'b1;
					end else if (dc_q[2]) begin
						n_err = 1'b1;
					end else begin
						n_cur = {cur_q[11:0], hx.value};
						n_dc  = dc_q + 3'd1;
						n_pc  = 1'b0;
					end
				end else if (char_s1 == ChColon) begin
					n_pc = 1'b1;
					if (dc_q != 3'd0) begin
						if (total >= 4'(GroupCount - 1)) begin
							n_err = 1'b1;
						end else begin
							if (gap_q) begin
								n_lo = {lo_q[GroupCount-2:0], cur_q};
								n_ga = ga_q + 4'd1;
							end else begin
								n_hi[gb_q[2:0]] = cur_q;
								n_gb = gb_q + 4'd1;
							end
							n_cur = 16'd0;
							n_dc  = 3'd0;
						end
					end else if (pc_q) begin
						if (gap_q) n_err = 1'b1;
						else       n_gap = 1'b1;
					end
				end else begin
					n_err = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.is_last;
		end
	end

	// group words are masked by the counts downstream
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hi_q  <= n_hi;
			lo_q  <= n_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gb_q  <= 4'd0;
			ga_q  <= 4'd0;
			cur_q <= 16'd0;
			dc_q  <= 3'd0;
			gap_q <= 1'b0;
			pc_q  <= 1'b0;
			cc_q  <= 6'd0;
			bo_q  <= 1'b0;
			st_q  <= 1'b1;
			err_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				gb_q  <= 4'd0;
				ga_q  <= 4'd0;
				cur_q <= 16'd0;
				dc_q  <= 3'd0;
				gap_q <= 1'b0;
				pc_q  <= 1'b0;
				cc_q  <= 6'd0;
				bo_q  <= 1'b0;
				st_q  <= 1'b1;
				err_q <= 1'b0;
			end else begin
				gb_q  <= n_gb;
				ga_q  <= n_ga;
				cur_q <= n_cur;
				dc_q  <= n_dc;
				gap_q <= n_gap;
				pc_q  <= n_pc;
				cc_q  <= n_cc;
				bo_q  <= n_bo;
				st_q  <= 1'b0;
				err_q <= n_err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			snap_valid_s2 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			snap_s2.hi         <= n_hi;
			snap_s2.lo         <= n_lo;
			snap_s2.gb         <= n_gb;
			snap_s2.ga         <= n_ga;
			snap_s2.cur        <= n_cur;
			snap_s2.has_digits <= (n_dc != 3'd0);
			snap_s2.gap        <= n_gap;
			snap_s2.err        <= n_err;
		end
	end

	assign snap       = snap_s2;
	assign snap_valid = snap_valid_s2;

endmodule

@@ rtl/ipv6p_pack.sv @@
// end-of-text checks and group expansion into the 128-bit result register
// depends on ipv6p_pkg and ipv6p_addr_if

module ipv6p_pack import ipv6p_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  scan_snap_t   snap,
	input  logic         snap_valid,
	output logic         snap_ready,
	ipv6p_addr_if.source addr
);

	logic        out_valid_q;
	logic        ok_q;
	logic [127:0] word_q;

	group_vec_t  hf, lf, grp;
	logic [3:0]  g1, g2, total;
	logic        err_f;

	assign snap_ready = !out_valid_q || addr.ready;
	assign total      = snap.gb + snap.ga;

	always_comb begin
		hf    = snap.hi;
		lf    = snap.lo;
		g1    = snap.gb;
		g2    = snap.ga;
		err_f = snap.err;
		if (!snap.err) begin
			if (snap.has_digits) begin
				if (total >= 4'(GroupCount)) begin
					err_f = 1'b1;
				end else if (snap.gap) begin
					lf = {snap.lo[GroupCount-2:0], snap.cur};
					g2 = snap.ga + 4'd1;
				end else begin
					hf[snap.gb[2:0]] = snap.cur;
					g1 = snap.gb + 4'd1;
				end
			end else if (!snap.gap || snap.ga != 4'd0) begin
				err_f = 1'b1;
			end
			if (!snap.gap && g1 != 4'(GroupCount)) err_f = 1'b1;
			if (snap.gap && (g1 + g2) > 4'(GroupCount - 1)) err_f = 1'b1;
		end
	end

	// group p lands at grp[7-p]; lf[0] holds the final group
	always_comb begin
		for (int p = 0; p < GroupCount; p++) begin
			if (4'(p) < g1)
				grp[GroupCount-1-p] = hf[p];
			else if (4'(p) >= 4'(GroupCount) - g2)
				grp[GroupCount-1-p] = lf[GroupCount-1-p];
			else
				grp[GroupCount-1-p] = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_ready) begin
			out_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			ok_q   <= !err_f;
			word_q <= err_f ? 128'd0 : grp;
		end
	end

	assign addr.valid      = out_valid_q;
	assign addr.addr_valid = ok_q;
	assign addr.addr_high  = word_q[127:64];
	assign addr.addr_low   = word_q[63:0];

endmodule

@@ rtl/ipv6_text_address_parser.sv @@
// IPv6 text address parser, one character beat in, one address beat out per text.
// Takes one character per cycle with no gaps, except while a last character waits as
// described below. The beat carrying is_last is first loaded into the input register, the
// character state update is then applied into the snapshot, and the expanded groups are
// then loaded into the output register, where the address beat is valid. While the
// snapshot and output registers are both full, a last character waits in the input
// register and chars.ready follows addr.ready.
// depends on ipv6p_pkg, ipv6p_char_if, ipv6p_addr_if, ipv6p_scan and ipv6p_pack

module ipv6_text_address_parser import ipv6p_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ipv6p_char_if.sink   chars,
	ipv6p_addr_if.source addr
);

	scan_snap_t snap;
	logic       snap_valid;
	logic       snap_ready;

	ipv6p_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.snap       (snap),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready)
	);

	ipv6p_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap       (snap),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.addr       (addr)
	);

endmodule

@@ rtl/ipv6p_checker.sv @@
// port-level checks of the ipv6 text parser and the bind that attaches them
// depends on ipv6_text_address_parser

module ipv6p_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic        addr_valid,
	input logic [63:0] addr_high,
	input logic [63:0] addr_low
);

	logic [2:0] pend_q;
	logic       in_done, out_done;

	assign in_done  = in_valid && in_ready && in_last;
	assign out_done = out_valid && out_ready;

	// texts whose last beat went in and whose result has not been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'd0, in_done} - {2'd0, out_done};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(addr_valid)
			&& $stable(addr_high) && $stable(addr_low))
		else $error("result beat changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !addr_valid |-> addr_high == 64'd0 && addr_low == 64'd0)
		else $error("invalid address with nonzero payload");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result beat without a finished text");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more finished texts in flight than the pipeline holds");

endmodule

bind ipv6_text_address_parser ipv6p_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (chars.valid),
	.in_ready   (chars.ready),
	.in_last    (chars.is_last),
	.out_valid  (addr.valid),
	.out_ready  (addr.ready),
	.addr_valid (addr.addr_valid),
	.addr_high  (addr.addr_high),
	.addr_low   (addr.addr_low)
);
